[rtl/rct_pkg.sv]
// Shared types and codes for the reassembly context table.
// No dependencies; the top, controller, datapath, checker and testbench import this package.
package rct_pkg;

   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FIND  = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;
   localparam logic [1:0] KIND_TICK  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
   localparam logic [1:0] STATUS_INACTIVE = 2'd3;

   localparam logic [31:0] MAX_AGE_RESET = 32'd1000;

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_TICK  = 4'd1;
   localparam logic [3:0] OP_FREE  = 4'd2;
   localparam logic [3:0] OP_EXP   = 4'd3;
   localparam logic [3:0] OP_SEL   = 4'd4;
   localparam logic [3:0] OP_PUSH  = 4'd5;
   localparam logic [3:0] OP_FIND  = 4'd6;
   localparam logic [3:0] OP_FRES  = 4'd7;
   localparam logic [3:0] OP_ALLOC = 4'd8;
   localparam logic [3:0] OP_LOAD  = 4'd9;

   typedef struct packed {
      logic       ready;
      logic [3:0] op;
   } rct_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] kind;
      logic       last;
      logic       best_valid;
      logic       out_free;
   } rct_sts_type;

endpackage

[rtl/rct_req_if.sv]
// Request channel interface of the reassembly context table.
// Depends on nothing.
interface rct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] tag;
   logic [63:0] src_addr;
   logic [3:0]  src_len;
   logic [2:0]  slot_in;
   modport source (output valid, kind, tag, src_addr, src_len, slot_in, input ready);
   modport sink (input valid, kind, tag, src_addr, src_len, slot_in, output ready);
endinterface

[rtl/rct_rsp_if.sv]
// Response channel interface of the reassembly context table.
// Depends on nothing.
interface rct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] slot_out;
   modport source (output valid, status, slot_out, input ready);
   modport sink (input valid, status, slot_out, output ready);
endinterface

[rtl/reassembly_context_table.sv]
// Top level of the reassembly context table: controller plus datapath.
// Depends on rct_pkg, rct_req_if, rct_rsp_if, rct_ctrl and rct_dpath.
//
//   Channel  Direction  Handshake            Word
//   req_ch   in         valid/ready          kind, tag, src_addr, src_len, slot_in
//   rsp_ch   out        valid/ready          status, slot_out
//   csr      in         csr_we, no wait      csr_wdata (max_age)
//
// Tick and free pass through acceptance, execution and output load.
// Allocate and find sweep the slots once to mark expiry, then once per expired slot
// plus once more, each sweep followed by a release step; find adds a matching sweep.
// A new word is accepted only after the previous response has been loaded.
// A full output register holds the controller before loading.
// Reset is synchronous; it fills the free stack and marks all slots inactive at once.
module reassembly_context_table import rct_pkg::*; #(
   parameter int NUM_SLOTS  = 8,
   parameter int ADDR_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   rct_req_if.sink     req_ch,
   rct_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   rct_cmd_type cmd;
   rct_sts_type sts;

   rct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   rct_dpath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .ADDR_BYTES (ADDR_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );
endmodule

[rtl/rct_ctrl.sv]
// Sequencing state machine of the reassembly context table.
// Depends on rct_pkg; drives the datapath through rct_cmd_type.
module rct_ctrl import rct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rct_sts_type sts,
   output rct_cmd_type cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_EXP    = 4'd2;
   localparam logic [3:0] S_SEL    = 4'd3;
   localparam logic [3:0] S_PUSH   = 4'd4;
   localparam logic [3:0] S_FIND   = 4'd5;
   localparam logic [3:0] S_FRES   = 4'd6;
   localparam logic [3:0] S_ALLOC  = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (sts.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (sts.kind)
               KIND_TICK: begin
                  cmd.op   = OP_TICK;
                  state_in = S_FINISH;
               end
               KIND_FREE: begin
                  cmd.op   = OP_FREE;
                  state_in = S_FINISH;
               end
               default: state_in = S_EXP;
            endcase
         end
         S_EXP: begin
            cmd.op = OP_EXP;
            if (sts.last) state_in = S_SEL;
         end
         S_SEL: begin
            cmd.op = OP_SEL;
            if (sts.last) state_in = S_PUSH;
         end
         S_PUSH: begin
            cmd.op = OP_PUSH;
            if (sts.best_valid) state_in = S_SEL;
            else if (sts.kind == KIND_ALLOC) state_in = S_ALLOC;
            else state_in = S_FIND;
         end
         S_FIND: begin
            cmd.op = OP_FIND;
            if (sts.last) state_in = S_FRES;
         end
         S_FRES: begin
            cmd.op   = OP_FRES;
            state_in = S_FINISH;
         end
         S_ALLOC: begin
            cmd.op   = OP_ALLOC;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.op   = OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

[rtl/rct_dpath.sv]
// Slot storage, free stack, scan unit and output register of the table.
// Depends on rct_pkg and the two channel interfaces.
module rct_dpath import rct_pkg::*; #(
   parameter int NUM_SLOTS  = 8,
   parameter int ADDR_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   rct_req_if.sink     req_ch,
   rct_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  rct_cmd_type cmd,
   output rct_sts_type sts
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int AW = 8 * ADDR_BYTES;
   localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);

   logic [SW-1:0] stack_ff [NUM_SLOTS];
   logic [CW-1:0] count_ff;
   logic          active_ff [NUM_SLOTS];
   logic          flag_ff [NUM_SLOTS];
   logic [15:0]   tag_ff [NUM_SLOTS];
   logic [AW-1:0] addr_ff [NUM_SLOTS];
   logic [3:0]    len_ff [NUM_SLOTS];
   logic [31:0]   start_ff [NUM_SLOTS];
   logic [31:0]   order_ff [NUM_SLOTS];
   logic [31:0]   now_ff;
   logic [31:0]   ord_cnt_ff;
   logic [31:0]   max_age_ff;

   logic [1:0]    kind_ff;
   logic [15:0]   q_tag_ff;
   logic [AW-1:0] q_addr_ff;
   logic [3:0]    q_len_ff;
   logic [2:0]    q_slot_ff;

   logic [SW-1:0] idx_ff;
   logic          bv_ff;
   logic [SW-1:0] best_ff;
   logic [31:0]   bage_ff;
   logic [1:0]    res_status_ff;
   logic [2:0]    res_slot_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [2:0]    rsp_slot_ff;

   logic [31:0]   age;
   logic [31:0]   elapsed;
   logic [AW-1:0] mask;
   logic          match;
   logic          cand;
   logic [SW-1:0] idx_in;
   logic          free_ok;
   logic [SW-1:0] free_idx;
   logic [SW+2:0] slot_in_ext;
   logic [SW+2:0] best_ext;
   logic [SW+2:0] pop_ext;
   logic [SW-1:0] pop_slot;
   logic [CW-1:0] pop_pos;

   assign req_ch.ready    = cmd.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.slot_out = rsp_slot_ff;

   assign sts.req_valid  = req_ch.valid;
   assign sts.kind       = kind_ff;
   assign sts.last       = (idx_ff == LAST_IDX);
   assign sts.best_valid = bv_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      for (int b = 0; b < ADDR_BYTES; b++) begin
         mask[8*b +: 8] = ({28'd0, q_len_ff} > b) ? 8'hff : 8'h00;
      end
   end

   assign age     = ord_cnt_ff - order_ff[idx_ff];
   assign elapsed = now_ff - start_ff[idx_ff];
   assign match   = (tag_ff[idx_ff] == q_tag_ff) && (len_ff[idx_ff] == q_len_ff)
                    && (((addr_ff[idx_ff] ^ q_addr_ff) & mask) == '0);
   assign cand    = active_ff[idx_ff] && ((cmd.op == OP_SEL) ? flag_ff[idx_ff] : match);
   assign idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   assign slot_in_ext = {{SW{1'b0}}, q_slot_ff};
   assign free_idx    = slot_in_ext[SW-1:0];
   assign free_ok     = ({29'd0, q_slot_ff} < NUM_SLOTS) && active_ff[free_idx];
   assign best_ext    = {3'b000, best_ff};
   assign pop_pos     = count_ff - 1'b1;
   assign pop_slot    = stack_ff[pop_pos[SW-1:0]];
   assign pop_ext     = {3'b000, pop_slot};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            stack_ff[i]  <= SW'(i);
            active_ff[i] <= 1'b0;
         end
         count_ff     <= FULL_CNT;
         now_ff       <= '0;
         ord_cnt_ff   <= '0;
         max_age_ff   <= MAX_AGE_RESET;
         idx_ff       <= '0;
         bv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) max_age_ff <= csr_wdata;
         if (cmd.op == OP_LOAD) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (cmd.ready && req_ch.valid) begin
            kind_ff   <= req_ch.kind;
            q_tag_ff  <= req_ch.tag;
            q_addr_ff <= req_ch.src_addr[AW-1:0];
            q_len_ff  <= req_ch.src_len;
            q_slot_ff <= req_ch.slot_in;
         end
         case (cmd.op)
            OP_TICK: begin
               now_ff        <= now_ff + 1'b1;
               res_status_ff <= STATUS_OK;
               res_slot_ff   <= '0;
            end
            OP_FREE: begin
               res_slot_ff <= '0;
               if (free_ok && count_ff < FULL_CNT) begin
                  active_ff[free_idx]         <= 1'b0;
                  stack_ff[count_ff[SW-1:0]] <= free_idx;
                  count_ff                    <= count_ff + 1'b1;
                  res_status_ff               <= STATUS_OK;
               end else if (free_ok) begin
                  active_ff[free_idx] <= 1'b0;
                  res_status_ff       <= STATUS_OK;
               end else begin
                  res_status_ff <= STATUS_INACTIVE;
               end
            end
            OP_EXP: begin
               flag_ff[idx_ff] <= active_ff[idx_ff] && (elapsed >= max_age_ff);
               idx_ff          <= idx_in;
               bv_ff           <= 1'b0;
            end
            OP_SEL, OP_FIND: begin
               if (cand && (!bv_ff || age < bage_ff)) begin
                  bv_ff   <= 1'b1;
                  best_ff <= idx_ff;
                  bage_ff <= age;
               end
               idx_ff <= idx_in;
            end
            OP_PUSH: begin
               if (bv_ff) begin
                  active_ff[best_ff] <= 1'b0;
                  flag_ff[best_ff]   <= 1'b0;
                  if (count_ff < FULL_CNT) begin
                     stack_ff[count_ff[SW-1:0]] <= best_ff;
                     count_ff                    <= count_ff + 1'b1;
                  end
               end
               bv_ff <= 1'b0;
            end
            OP_FRES: begin
               if (bv_ff) begin
                  res_status_ff <= STATUS_OK;
                  res_slot_ff   <= best_ext[2:0];
               end else begin
                  res_status_ff <= STATUS_NOTFOUND;
                  res_slot_ff   <= '0;
               end
            end
            OP_ALLOC: begin
               if (count_ff == '0) begin
                  res_status_ff <= STATUS_FULL;
                  res_slot_ff   <= '0;
               end else begin
                  count_ff            <= pop_pos;
                  active_ff[pop_slot] <= 1'b1;
                  tag_ff[pop_slot]    <= q_tag_ff;
                  addr_ff[pop_slot]   <= q_addr_ff;
                  len_ff[pop_slot]    <= q_len_ff;
                  start_ff[pop_slot]  <= now_ff;
                  order_ff[pop_slot]  <= ord_cnt_ff;
                  ord_cnt_ff          <= ord_cnt_ff + 1'b1;
                  res_status_ff       <= STATUS_OK;
                  res_slot_ff         <= pop_ext[2:0];
               end
            end
            OP_LOAD: begin
               rsp_status_ff <= res_status_ff;
               rsp_slot_ff   <= res_slot_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

[test/rct_check.sv]
// Checker for the reassembly context table: watches both channels, predicts each response word.
// Depends on rct_pkg, rct_req_if and rct_rsp_if; the testbench top passes the max_age setting in.
module rct_check import rct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rct_req_if          req_ch,
   rct_rsp_if          rsp_ch,
   input  logic [31:0] max_age,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 8;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] slot;
   } rsp_word_type;

   rsp_word_type expected_rsp[$];
   logic [2:0]  free_stack[SLOTS];
   int          free_count;
   logic        active[SLOTS];
   logic [15:0] ctx_tag[SLOTS];
   logic [63:0] ctx_addr[SLOTS];
   logic [3:0]  ctx_len[SLOTS];
   logic [31:0] ctx_start[SLOTS];
   logic [31:0] ctx_order[SLOTS];
   logic [31:0] now_ticks;
   logic [31:0] alloc_count;

   function automatic int newest_slot(logic sel[SLOTS]);
      int best;
      logic [31:0] best_age, age;
      best = SLOTS;
      best_age = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (active[i] && sel[i]) begin
            age = alloc_count - ctx_order[i];
            if (best == SLOTS || age < best_age) begin
               best = i;
               best_age = age;
            end
         end
      end
      return best;
   endfunction

   task automatic expire_old();
      logic sel[SLOTS];
      int s;
      for (int i = 0; i < SLOTS; i++)
         sel[i] = active[i] && ((now_ticks - ctx_start[i]) >= max_age);
      forever begin
         s = newest_slot(sel);
         if (s >= SLOTS) break;
         active[s] = 1'b0;
         sel[s] = 1'b0;
         if (free_count < SLOTS) begin
            free_stack[free_count] = s[2:0];
            free_count++;
         end
      end
   endtask

   task automatic predict_rsp(logic [1:0] kind, logic [15:0] tag, logic [63:0] addr,
                              logic [3:0] len, logic [2:0] slot_in);
      rsp_word_type w;
      logic sel[SLOTS];
      logic [63:0] mask;
      int s;
      w.status = STATUS_OK;
      w.slot = 3'd0;
      case (kind)
         KIND_ALLOC: begin
            expire_old();
            if (free_count == 0) begin
               w.status = STATUS_FULL;
            end else begin
               free_count--;
               s = free_stack[free_count];
               active[s] = 1'b1;
               ctx_tag[s] = tag;
               ctx_addr[s] = addr;
               ctx_len[s] = len;
               ctx_start[s] = now_ticks;
               ctx_order[s] = alloc_count;
               alloc_count++;
               w.slot = s[2:0];
            end
         end
         KIND_FIND: begin
            mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
            expire_old();
            for (int i = 0; i < SLOTS; i++)
               sel[i] = ctx_tag[i] == tag && ctx_len[i] == len &&
                        ((ctx_addr[i] ^ addr) & mask) == 0;
            s = newest_slot(sel);
            if (s >= SLOTS) w.status = STATUS_NOTFOUND;
            else w.slot = s[2:0];
         end
         KIND_FREE: begin
            if (!active[slot_in]) begin
               w.status = STATUS_INACTIVE;
            end else begin
               active[slot_in] = 1'b0;
               free_stack[free_count] = slot_in;
               free_count++;
            end
         end
         default: now_ticks++;
      endcase
      expected_rsp.push_back(w);
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         expected_rsp.delete();
         for (int i = 0; i < SLOTS; i++) begin
            free_stack[i] = i[2:0];
            active[i] = 1'b0;
            ctx_tag[i] = '0;
            ctx_addr[i] = '0;
            ctx_len[i] = '0;
            ctx_start[i] = '0;
            ctx_order[i] = '0;
         end
         free_count = SLOTS;
         now_ticks = '0;
         alloc_count = '0;
         fail_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response word with none expected: status %0d slot %0d",
                      rsp_ch.status, rsp_ch.slot_out);
               fail_count++;
            end else begin
               w = expected_rsp.pop_front();
               if (rsp_ch.status !== w.status) begin
                  $error("status: expected %0d, actual %0d", w.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.slot_out !== w.slot) begin
                  $error("slot_out: expected %0d, actual %0d", w.slot, rsp_ch.slot_out);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_rsp(req_ch.kind, req_ch.tag, req_ch.src_addr, req_ch.src_len,
                        req_ch.slot_in);
      end
      pending = expected_rsp.size();
   end
endmodule

[test/tb.sv]
// Testbench top for the reassembly context table: drives requests and max_age writes.
// Depends on rct_pkg, the channel interfaces, rct_check and the block itself.
module tb import rct_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic [31:0] max_age = MAX_AGE_RESET;
   int          fail_count;
   int          pending;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          hold_off = 0;
   int          cycles = 0;
   logic [15:0] recent_tag[4];
   logic [63:0] recent_addr[4];
   logic [3:0]  recent_len[4];

   rct_req_if req_ch();
   rct_rsp_if rsp_ch();

   reassembly_context_table i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   rct_check i_check (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .max_age(max_age), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.tag = '0;
      req_ch.src_addr = '0;
      req_ch.src_len = '0;
      req_ch.slot_in = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_off > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_req(logic [1:0] kind, logic [15:0] tag, logic [63:0] addr,
                           logic [3:0] len, logic [2:0] slot_in);
      if ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.tag <= tag;
      req_ch.src_addr <= addr;
      req_ch.src_len <= len;
      req_ch.slot_in <= slot_in;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_max_age(logic [31:0] value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      max_age <= value;
      @(posedge clock);
   endtask

   task automatic random_req();
      int pick, r;
      logic [63:0] addr;
      logic [3:0] len;
      logic [15:0] tag;
      pick = $urandom_range(99);
      r = $urandom_range(3);
      addr = {$urandom, $urandom};
      len = 4'($urandom_range(15));
      tag = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3));
      if (pick < 30) begin
         send_req(KIND_ALLOC, tag, addr, len, 3'($urandom));
         recent_tag[r] = tag;
         recent_addr[r] = addr;
         recent_len[r] = len;
      end else if (pick < 55) begin
         if ($urandom_range(3) != 0)
            send_req(KIND_FIND, recent_tag[r], recent_addr[r] ^
                     ({$urandom, $urandom} << (8 * recent_len[r])), recent_len[r], 3'($urandom));
         else send_req(KIND_FIND, tag, addr, len, 3'($urandom));
      end else if (pick < 75) begin
         send_req(KIND_FREE, 16'($urandom), addr, len, 3'($urandom));
      end else begin
         send_req(KIND_TICK, 16'($urandom), addr, len, 3'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < 4; i++) begin
         recent_tag[i] = '0;
         recent_addr[i] = '0;
         recent_len[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      send_req(KIND_FREE, '0, '0, '0, 3'd7);
      send_req(KIND_FIND, 16'hffff, '1, 4'd8, '0);
      for (int i = 0; i < 8; i++)
         send_req(KIND_ALLOC, (i == 0) ? 16'hffff : 16'(i), (i == 0) ? '1 : 64'(i),
                  4'(i + 8), 3'd0);
      send_req(KIND_ALLOC, 16'd9, '0, 4'd0, '0);
      send_req(KIND_FIND, 16'hffff, '1, 4'd8, '0);
      send_req(KIND_FIND, 16'd7, 64'hffff_ff00_0000_0007, 4'd15, '0);
      send_req(KIND_FIND, 16'd3, 64'd3, 4'd3, '0);
      send_req(KIND_FREE, '0, '0, '0, 3'd3);
      send_req(KIND_FREE, '0, '0, '0, 3'd3);
      send_req(KIND_ALLOC, 16'd3, 64'd3, 4'd11, '0);
      send_req(KIND_FIND, 16'd3, 64'd3, 4'd11, '0);
      write_max_age(32'd0);
      send_req(KIND_FIND, 16'd3, 64'd3, 4'd11, '0);
      write_max_age(32'd1);
      send_req(KIND_ALLOC, 16'd1, 64'd1, 4'd1, '0);
      send_req(KIND_TICK, '0, '0, '0, '0);
      send_req(KIND_FIND, 16'd1, 64'd1, 4'd1, '0);
      write_max_age(32'hffff_ffff);

      send_idle = 27;
      recv_idle = 86;
      for (int i = 0; i < 200; i++) random_req();
      write_max_age(32'd3);
      send_idle = 86;
      recv_idle = 27;
      for (int i = 0; i < 200; i++) random_req();
      write_max_age(32'd20);
      send_idle = 0;
      recv_idle = 0;
      hold_off = 400;
      for (int i = 0; i < 100; i++) random_req();
      drain();
      for (int i = 0; i < 150; i++) random_req();

      drain();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
